### sv/timed_request_reply_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed request/reply checker
// Clocked concurrent assertion wrappers that report through $error.
// ----------------------------------------------------------------------------
`ifndef TIMED_REQUEST_REPLY_CHECKER_UNIT_DEFINES_SVH
`define TIMED_REQUEST_REPLY_CHECKER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define TRRC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define TRRC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/trrc_pkg.sv
// ----------------------------------------------------------------------------
// trrc_pkg
// Types, codes and reset values shared by the request/reply checker.
// ----------------------------------------------------------------------------
package trrc_pkg;

   localparam int unsigned MaxReplyBytes = 4;

   // func codes
   localparam logic [1:0] FuncBeginTx = 2'd0;
   localparam logic [1:0] FuncBeginRx = 2'd1;
   localparam logic [1:0] FuncPoll    = 2'd2;

   // put_status codes
   localparam logic [1:0] PutReady   = 2'd0;
   localparam logic [1:0] PutEmpty   = 2'd1;
   localparam logic [1:0] PutBlocked = 2'd2;
   localparam logic [1:0] PutError   = 2'd3;

   // get_status codes
   localparam logic [1:0] GetReady = 2'd0;
   localparam logic [1:0] GetEmpty = 2'd1;

   // failure codes
   localparam logic [3:0] FailNone       = 4'd0;
   localparam logic [3:0] FailStall      = 4'd1;
   localparam logic [3:0] FailTxTimeout  = 4'd2;
   localparam logic [3:0] FailTxError    = 4'd3;
   localparam logic [3:0] FailNoReply    = 4'd4;
   localparam logic [3:0] FailIncomplete = 4'd5;
   localparam logic [3:0] FailExtra      = 4'd6;
   localparam logic [3:0] FailWrong      = 4'd7;
   localparam logic [3:0] FailRxError    = 4'd8;

   // register indexes
   localparam logic [2:0] RegTransmitLimit = 3'd0;
   localparam logic [2:0] RegReceiveLimit  = 3'd1;
   localparam logic [2:0] RegQuietUnits    = 3'd2;
   localparam logic [2:0] RegStallPolls    = 3'd3;
   localparam logic [2:0] RegBlockedWaits  = 3'd4;
   localparam logic [2:0] RegReplyPattern  = 3'd5;
   localparam logic [2:0] RegReplyCount    = 3'd6;

   // register reset values
   localparam logic [15:0] TransmitLimitRst = 16'd120;
   localparam logic [15:0] ReceiveLimitRst  = 16'd600;
   localparam logic [15:0] QuietUnitsRst    = 16'd24;
   localparam logic [15:0] StallPollsRst    = 16'hFFFF;
   localparam logic        BlockedWaitsRst  = 1'b1;
   localparam logic [31:0] ReplyPatternRst  = 32'h00A5_0180;
   localparam logic [2:0]  ReplyCountRst    = 3'd3;

   localparam logic [15:0] CountMax = 16'hFFFF;

   typedef enum logic [1:0] {
      PhIdle = 2'd0,
      PhTx   = 2'd1,
      PhRx   = 2'd2,
      PhEnd  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [15:0] transmit_limit;
      logic [15:0] receive_limit;
      logic [15:0] quiet_units;
      logic [15:0] stall_polls;
      logic        blocked_waits;
      logic [31:0] reply_pattern;
      logic [2:0]  reply_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  last_clock;
      logic [15:0] elapsed_units;
      logic [15:0] stall_left;
      logic [15:0] sent_total;
      logic [2:0]  got_total;
      logic [15:0] complete_time;
      phase_type   phase;
      logic [3:0]  failure;
   } state_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] clock_sample;
      logic [7:0] tx_byte;
      logic       tx_final;
      logic [1:0] put_status;
      logic [1:0] get_status;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  offered_byte;
      logic        phase_done;
      logic        passed;
      logic [3:0]  fail_code;
      logic [15:0] sent_count;
      logic [2:0]  received_count;
   } rsp_type;

endpackage

### sv/timed_request_reply_checker_unit.sv
// ----------------------------------------------------------------------------
// timed_request_reply_checker_unit
// Checks one timed request/reply exchange on a serial port. Send begin-transmit,
// poll while bytes go out, then begin-receive and poll until the reply and the
// quiet interval are seen; every transfer returns exactly one result. Time is
// rebuilt from 8-bit wrapping clock samples and saturates at 65535 units. The
// unit takes one request transfer per clock while the result side does not stall;
// each transfer is held first in the request register, then its result in the
// result register. Throughput is set by the single update stage that reads and
// writes the exchange state each cycle; a stalled result side holds both registers.
// Write the control registers only while no transfer is in flight.
// ----------------------------------------------------------------------------
`include "timed_request_reply_checker_unit_defines.svh"

module timed_request_reply_checker_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: clock_sample[7:0], tx_byte[15:8], put_status[17:16],
   //        get_status[19:18], rx_byte[27:20], zero[31:28]
   input  logic [31:0] req_tdata,
   // tuser: func[1:0]
   input  logic [1:0]  req_tuser,
   // tlast: tx_final
   input  logic        req_tlast,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: offered_byte[7:0], passed[8], fail_code[12:9],
   //        sent_count[28:13], received_count[31:29]
   output logic [31:0] rsp_tdata,
   // tlast: phase_done
   output logic        rsp_tlast,
   // control register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   trrc_pkg::cfg_type   cfg_ff;
   trrc_pkg::req_type   req_ff;
   logic                req_valid_ff;
   trrc_pkg::state_type state_ff;
   trrc_pkg::state_type state_in;
   trrc_pkg::rsp_type   rsp_ff;
   trrc_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                advance;

   // Move the held request into the result register when the result slot frees.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transmit_limit <= trrc_pkg::TransmitLimitRst;
         cfg_ff.receive_limit  <= trrc_pkg::ReceiveLimitRst;
         cfg_ff.quiet_units    <= trrc_pkg::QuietUnitsRst;
         cfg_ff.stall_polls    <= trrc_pkg::StallPollsRst;
         cfg_ff.blocked_waits  <= trrc_pkg::BlockedWaitsRst;
         cfg_ff.reply_pattern  <= trrc_pkg::ReplyPatternRst;
         cfg_ff.reply_count    <= trrc_pkg::ReplyCountRst;
      end else if (csr_we) begin
         unique case (csr_index)
            trrc_pkg::RegTransmitLimit: cfg_ff.transmit_limit <= csr_wdata[15:0];
            trrc_pkg::RegReceiveLimit:  cfg_ff.receive_limit  <= csr_wdata[15:0];
            trrc_pkg::RegQuietUnits:    cfg_ff.quiet_units    <= csr_wdata[15:0];
            trrc_pkg::RegStallPolls:    cfg_ff.stall_polls    <= csr_wdata[15:0];
            trrc_pkg::RegBlockedWaits:  cfg_ff.blocked_waits  <= csr_wdata[0];
            trrc_pkg::RegReplyPattern:  cfg_ff.reply_pattern  <= csr_wdata;
            trrc_pkg::RegReplyCount:    cfg_ff.reply_count    <= csr_wdata[2:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // Request register: take a transfer whenever the slot is free or draining.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.func         <= req_tuser;
         req_ff.clock_sample <= req_tdata[7:0];
         req_ff.tx_byte      <= req_tdata[15:8];
         req_ff.tx_final     <= req_tlast;
         req_ff.put_status   <= req_tdata[17:16];
         req_ff.get_status   <= req_tdata[19:18];
         req_ff.rx_byte      <= req_tdata[27:20];
      end
   end

   trrc_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Exchange state: advance once per transfer that moves into the result slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_clock    <= 8'd0;
         state_ff.elapsed_units <= 16'd0;
         state_ff.stall_left    <= trrc_pkg::StallPollsRst;
         state_ff.sent_total    <= 16'd0;
         state_ff.got_total     <= 3'd0;
         state_ff.complete_time <= 16'd0;
         state_ff.phase         <= trrc_pkg::PhIdle;
         state_ff.failure       <= trrc_pkg::FailNone;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: hold until the downstream side takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.phase_done;
   assign rsp_tdata  = {rsp_ff.received_count, rsp_ff.sent_count, rsp_ff.fail_code,
                        rsp_ff.passed, rsp_ff.offered_byte};

   // A pass is always a clean end of the phase.
   `TRRC_ASSERT(a_pass_is_clean_end, rsp_valid_ff && rsp_ff.passed |-> rsp_ff.phase_done && rsp_ff.fail_code == trrc_pkg::FailNone, "pass without clean phase end")

   // A pending phase-done result means the state has already ended.
   `TRRC_ASSERT(a_done_means_ended, rsp_valid_ff && rsp_ff.phase_done |-> state_ff.phase == trrc_pkg::PhEnd, "phase done but state not ended")

   // Backpressure on the request side only comes from a full, stalled pipe.
   `TRRC_ASSERT(a_ready_low_only_when_full, !req_tready |-> req_valid_ff && rsp_valid_ff && !rsp_tready, "request stalled with free slot")

   // The match count never runs past the longest reply; the state is unknown
   // until the first reset edge has loaded it.
   `TRRC_ASSERT_ALWAYS(a_got_in_range, reset || state_ff.got_total <= 3'(trrc_pkg::MaxReplyBytes), "reply count overrun")

endmodule

### sv/trrc_step.sv
// ----------------------------------------------------------------------------
// trrc_step
// Next-state and result logic for one transfer of the exchange checker.
// ----------------------------------------------------------------------------
module trrc_step (
   input  trrc_pkg::cfg_type   cfg,
   input  trrc_pkg::state_type cur,
   input  trrc_pkg::req_type   req,
   output trrc_pkg::state_type nxt,
   output trrc_pkg::rsp_type   rsp
);

   logic [7:0]  delta;
   logic [16:0] elapsed_sum;
   logic [15:0] elapsed_adv;
   logic [15:0] stall_adv;
   logic        stall_fail;
   logic [2:0]  reply_len;
   logic [7:0]  expect_byte;
   logic        is_poll;
   logic        done;
   logic        pass;
   logic [3:0]  fail_set;
   logic        sent_inc;
   logic [2:0]  got_adv;
   logic [15:0] ctime_adv;
   logic [15:0] quiet_gap;

   // Coarse clock: wrapped difference, saturating sum, stall countdown.
   always_comb begin
      delta       = req.clock_sample - cur.last_clock;
      elapsed_sum = {1'b0, cur.elapsed_units} + {9'd0, delta};
      elapsed_adv = elapsed_sum[16] ? trrc_pkg::CountMax : elapsed_sum[15:0];
      stall_fail  = (delta == 8'd0) && (cur.stall_left <= 16'd1);
      if (delta != 8'd0) begin
         stall_adv = cfg.stall_polls;
      end else if (cur.stall_left <= 16'd1) begin
         stall_adv = 16'd0;
      end else begin
         stall_adv = cur.stall_left - 16'd1;
      end
   end

   // Effective reply length and the byte expected next.
   always_comb begin
      if (cfg.reply_count == 3'd0) begin
         reply_len = 3'd1;
      end else if (cfg.reply_count > 3'(trrc_pkg::MaxReplyBytes)) begin
         reply_len = 3'(trrc_pkg::MaxReplyBytes);
      end else begin
         reply_len = cfg.reply_count;
      end
      // only looked at while got_total is below the reply length
      expect_byte = cfg.reply_pattern[{cur.got_total[1:0], 3'b000} +: 8];
   end

   // Poll decision in the running phases.
   always_comb begin
      is_poll   = (req.func == trrc_pkg::FuncPoll);
      done      = 1'b0;
      pass      = 1'b0;
      fail_set  = trrc_pkg::FailNone;
      sent_inc  = 1'b0;
      got_adv   = cur.got_total;
      ctime_adv = cur.complete_time;
      quiet_gap = 16'd0;
      if (is_poll && cur.phase == trrc_pkg::PhTx) begin
         if (stall_fail) begin
            fail_set = trrc_pkg::FailStall;
            done     = 1'b1;
         end else if (elapsed_adv >= cfg.transmit_limit) begin
            fail_set = trrc_pkg::FailTxTimeout;
            done     = 1'b1;
         end else begin
            case (req.put_status)
               trrc_pkg::PutReady: begin
                  sent_inc = (cur.sent_total != trrc_pkg::CountMax);
                  done     = req.tx_final;
               end
               trrc_pkg::PutBlocked: begin
                  if (!cfg.blocked_waits) begin
                     fail_set = trrc_pkg::FailTxError;
                     done     = 1'b1;
                  end
               end
               trrc_pkg::PutError: begin
                  fail_set = trrc_pkg::FailTxError;
                  done     = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end else if (is_poll && cur.phase == trrc_pkg::PhRx) begin
         if (stall_fail) begin
            fail_set = trrc_pkg::FailStall;
            done     = 1'b1;
         end else if (elapsed_adv >= cfg.receive_limit) begin
            fail_set = (cur.got_total != 3'd0) ? trrc_pkg::FailIncomplete
                                               : trrc_pkg::FailNoReply;
            done     = 1'b1;
         end else begin
            if (req.get_status == trrc_pkg::GetReady) begin
               if (cur.got_total >= reply_len) begin
                  fail_set = trrc_pkg::FailExtra;
                  done     = 1'b1;
               end else if (req.rx_byte != expect_byte) begin
                  fail_set = trrc_pkg::FailWrong;
                  done     = 1'b1;
               end else begin
                  got_adv = cur.got_total + 3'd1;
                  if (got_adv == reply_len) begin
                     ctime_adv = elapsed_adv;
                  end
               end
            end else if (req.get_status != trrc_pkg::GetEmpty) begin
               fail_set = trrc_pkg::FailRxError;
               done     = 1'b1;
            end
            quiet_gap = elapsed_adv - ctime_adv;
            if (!done && got_adv >= reply_len && quiet_gap >= cfg.quiet_units) begin
               done = 1'b1;
               pass = 1'b1;
            end
         end
      end
   end

   // Next state.
   always_comb begin
      nxt = cur;
      unique case (req.func)
         trrc_pkg::FuncBeginTx, trrc_pkg::FuncBeginRx: begin
            nxt.last_clock    = req.clock_sample;
            nxt.elapsed_units = 16'd0;
            nxt.stall_left    = cfg.stall_polls;
            nxt.got_total     = 3'd0;
            nxt.complete_time = 16'd0;
            nxt.failure       = trrc_pkg::FailNone;
            if (req.func == trrc_pkg::FuncBeginTx) begin
               nxt.sent_total = 16'd0;
               nxt.phase      = trrc_pkg::PhTx;
            end else begin
               nxt.phase      = trrc_pkg::PhRx;
            end
         end
         trrc_pkg::FuncPoll: begin
            if (cur.phase == trrc_pkg::PhTx || cur.phase == trrc_pkg::PhRx) begin
               nxt.last_clock    = req.clock_sample;
               nxt.elapsed_units = elapsed_adv;
               nxt.stall_left    = stall_adv;
               nxt.got_total     = got_adv;
               nxt.complete_time = ctime_adv;
               if (sent_inc) begin
                  nxt.sent_total = cur.sent_total + 16'd1;
               end
               if (fail_set != trrc_pkg::FailNone) begin
                  nxt.failure = fail_set;
               end
               if (done) begin
                  nxt.phase = trrc_pkg::PhEnd;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result.
   always_comb begin
      rsp.offered_byte   = (is_poll && cur.phase == trrc_pkg::PhTx) ? req.tx_byte : 8'd0;
      rsp.phase_done     = done;
      rsp.passed         = pass;
      rsp.fail_code      = is_poll ? nxt.failure : trrc_pkg::FailNone;
      rsp.sent_count     = nxt.sent_total;
      rsp.received_count = nxt.got_total;
   end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the timed request/reply checker
// Drives begin and poll transfers into the request stream, predicts every
// result with a cycle-free model of the exchange state, and compares each
// result transfer against the oldest prediction. A short table of directed
// rows comes first, then randomized exchanges under several register settings.
// ----------------------------------------------------------------------------
module tb;
   import trrc_pkg::*;

   // get_status code with no name in the package
   localparam logic [1:0] GetFault = 2'd2;

   localparam int unsigned WatchdogLimit   = 2000;
   localparam int unsigned SettingCount    = 10;
   localparam int unsigned ItemsPerSetting = 170;

   typedef struct packed {
      logic       is_reg;
      logic [2:0] reg_index;
      logic [31:0] reg_value;
      logic       typed;
      req_type    item;
      rsp_type    want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // no idling on either side once set
   logic        steady = 1'b0;

   // shadow registers and exchange state of the prediction
   cfg_type     cfg;
   state_type   st;

   rsp_type     pending_results[$];
   rsp_type     seen_results[$];
   int unsigned mismatches = 0;
   int unsigned items_run = 0;
   int unsigned idle_cycles = 0;
   int unsigned rsp_hold = 0;

   timed_request_reply_checker_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Exchange prediction
   // ------------------------------------------------------------------------

   // effective reply length: zero counts as one, clip at the maximum
   function automatic logic [2:0] reply_span();
      if (cfg.reply_count == 3'd0) return 3'd1;
      if (cfg.reply_count > MaxReplyBytes) return 3'(MaxReplyBytes);
      return cfg.reply_count;
   endfunction

   function automatic logic [7:0] pattern_byte(logic [2:0] idx);
      return cfg.reply_pattern[8 * idx +: 8];
   endfunction

   // Advance the exchange state by one accepted transfer and form its result.
   task automatic step_exchange(input req_type r, output rsp_type o);
      logic [7:0]  delta;
      logic [16:0] sum;
      logic        moving;
      logic        done;
      logic        pass;
      logic [2:0]  need;
      begin
         o      = '0;
         done   = 1'b0;
         pass   = 1'b0;
         moving = 1'b1;
         need   = reply_span();
         if (r.func == FuncBeginTx || r.func == FuncBeginRx) begin
            st.last_clock    = r.clock_sample;
            st.elapsed_units = '0;
            st.stall_left    = cfg.stall_polls;
            st.got_total     = '0;
            st.complete_time = '0;
            st.failure       = FailNone;
            if (r.func == FuncBeginTx) begin
               st.sent_total = '0;
               st.phase      = PhTx;
            end else begin
               st.phase = PhRx;
            end
         end else if (r.func == FuncPoll && (st.phase == PhTx || st.phase == PhRx)) begin
            // wrapped clock difference, saturating elapsed time
            delta         = r.clock_sample - st.last_clock;
            st.last_clock = r.clock_sample;
            sum           = {1'b0, st.elapsed_units} + {9'd0, delta};
            st.elapsed_units = sum[16] ? CountMax : sum[15:0];
            if (delta != 8'd0) begin
               st.stall_left = cfg.stall_polls;
            end else if (st.stall_left <= 16'd1) begin
               st.stall_left = '0;
               moving        = 1'b0;
            end else begin
               st.stall_left--;
            end

            if (st.phase == PhTx) begin
               o.offered_byte = r.tx_byte;
               if (!moving) begin
                  st.failure = FailStall;
                  done       = 1'b1;
               end else if (st.elapsed_units >= cfg.transmit_limit) begin
                  st.failure = FailTxTimeout;
                  done       = 1'b1;
               end else if (r.put_status == PutReady) begin
                  if (st.sent_total != CountMax) st.sent_total++;
                  if (r.tx_final) done = 1'b1;
               end else if (r.put_status == PutBlocked) begin
                  if (!cfg.blocked_waits) begin
                     st.failure = FailTxError;
                     done       = 1'b1;
                  end
               end else if (r.put_status == PutError) begin
                  st.failure = FailTxError;
                  done       = 1'b1;
               end
            end else begin
               if (!moving) begin
                  st.failure = FailStall;
                  done       = 1'b1;
               end else if (st.elapsed_units >= cfg.receive_limit) begin
                  st.failure = (st.got_total != 3'd0) ? FailIncomplete : FailNoReply;
                  done       = 1'b1;
               end else begin
                  if (r.get_status == GetReady) begin
                     if (st.got_total >= need) begin
                        st.failure = FailExtra;
                        done       = 1'b1;
                     end else if (r.rx_byte != pattern_byte(st.got_total)) begin
                        st.failure = FailWrong;
                        done       = 1'b1;
                     end else begin
                        st.got_total++;
                        if (st.got_total == need) st.complete_time = st.elapsed_units;
                     end
                  end else if (r.get_status != GetEmpty) begin
                     st.failure = FailRxError;
                     done       = 1'b1;
                  end
                  // full reply followed by enough silence
                  if (!done && st.got_total >= need &&
                      st.elapsed_units - st.complete_time >= cfg.quiet_units) begin
                     done = 1'b1;
                     pass = 1'b1;
                  end
               end
            end
            if (done) st.phase = PhEnd;
         end
         o.phase_done     = done;
         o.passed         = pass;
         o.fail_code      = (r.func == FuncPoll) ? st.failure : FailNone;
         o.sent_count     = st.sent_total;
         o.received_count = st.got_total;
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one request transfer, hold it until taken, then log its result.
   task automatic send_item(input req_type r, input logic typed, input rsp_type want);
      rsp_type predicted;
      begin
         if (!steady && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {4'b0, r.rx_byte, r.get_status, r.put_status, r.tx_byte,
                        r.clock_sample};
         req_tuser  <= r.func;
         req_tlast  <= r.tx_final;
         do @(posedge clock); while (req_tready !== 1'b1);
         // polls outside a running phase change nothing; leave them out of the count
         if (r.func != FuncPoll || st.phase == PhTx || st.phase == PhRx) items_run++;
         step_exchange(r, predicted);
         pending_results.push_back(typed ? want : predicted);
      end
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         RegTransmitLimit: cfg.transmit_limit = value[15:0];
         RegReceiveLimit:  cfg.receive_limit  = value[15:0];
         RegQuietUnits:    cfg.quiet_units    = value[15:0];
         RegStallPolls:    cfg.stall_polls    = value[15:0];
         RegBlockedWaits:  cfg.blocked_waits  = value[0];
         RegReplyPattern:  cfg.reply_pattern  = value;
         RegReplyCount:    cfg.reply_count    = value[2:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Random stimulus
   // ------------------------------------------------------------------------

   function automatic req_type random_request();
      req_type r;
      r.func         = 2'($urandom_range(0, 2));
      r.clock_sample = 8'($urandom);
      r.tx_byte      = 8'($urandom);
      r.tx_final     = 1'($urandom);
      r.put_status   = 2'($urandom_range(0, 3));
      r.get_status   = 2'($urandom_range(0, 2));
      r.rx_byte      = 8'($urandom);
      return r;
   endfunction

   // clock step per poll: crawling (stalls), steady, fast (saturation), anything
   function automatic logic [7:0] next_delta(int unsigned mode);
      case (mode)
         0:       return 8'($urandom_range(0, 2));
         1:       return 8'($urandom_range(1, 8));
         2:       return 8'($urandom_range(100, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // level 1 picks the top of the range, level 2 the bottom, 0 anything
   function automatic logic [31:0] pick16(int unsigned level, int unsigned lo,
                                          int unsigned typ_lo, int unsigned typ_hi);
      if (level == 1) return 32'hFFFF;
      if (level == 2) return lo;
      case ($urandom_range(0, 5))
         0:       return lo;
         1:       return 32'hFFFF;
         default: return $urandom_range(typ_lo, typ_hi);
      endcase
   endfunction

   task automatic apply_setting(input int unsigned level);
      logic [31:0] pattern;
      logic [31:0] count;
      begin
         pattern = (level == 1) ? 32'hFFFF_FFFF : (level == 2) ? 32'h0 : $urandom;
         if (level == 1) count = 4;
         else if (level == 2) count = 1;
         else if ($urandom_range(0, 3) == 0) count = $urandom_range(0, 7);
         else count = $urandom_range(1, 4);
         write_register(RegTransmitLimit, pick16(level, 1, 10, 200));
         write_register(RegReceiveLimit, pick16(level, 1, 40, 600));
         write_register(RegQuietUnits, pick16(level, 0, 0, 30));
         write_register(RegStallPolls, pick16(level, 1, 2, 6));
         write_register(RegBlockedWaits,
                        (level == 1) ? 1 : (level == 2) ? 0 : $urandom_range(0, 1));
         write_register(RegReplyPattern, pattern);
         write_register(RegReplyCount, count);
      end
   endtask

   // One mostly well-formed exchange: transmit run, receive run, some noise.
   task automatic run_exchange();
      int unsigned mode;
      int unsigned planned;
      int unsigned polls;
      int unsigned poll_cap;
      int unsigned roll;
      logic [7:0]  clk;
      req_type     r;
      begin
         mode     = $urandom_range(0, 3);
         poll_cap = (mode == 2) ? 400 : 60;
         planned  = $urandom_range(1, 6);
         clk      = 8'($urandom);

         // transmit phase, skipped now and then
         if ($urandom_range(0, 5) != 0) begin
            r              = random_request();
            r.func         = FuncBeginTx;
            r.clock_sample = clk;
            send_item(r, 1'b0, '0);
            polls = 0;
            while (st.phase == PhTx && polls < poll_cap) begin
               r              = random_request();
               clk            = clk + next_delta(mode);
               r.func         = FuncPoll;
               r.clock_sample = clk;
               roll           = $urandom_range(0, 99);
               r.put_status   = (roll < 60) ? PutReady : (roll < 78) ? PutEmpty :
                                (roll < 96) ? PutBlocked : PutError;
               if (r.put_status == PutReady && st.sent_total + 1 >= planned)
                  r.tx_final = 1'b1;
               else
                  r.tx_final = ($urandom_range(0, 19) == 0);
               send_item(r, 1'b0, '0);
               polls++;
            end
         end

         // receive phase: mostly the right bytes with gaps, then silence
         r              = random_request();
         r.func         = FuncBeginRx;
         r.clock_sample = clk;
         send_item(r, 1'b0, '0);
         polls = 0;
         while (st.phase == PhRx && polls < poll_cap) begin
            r              = random_request();
            clk            = clk + next_delta(mode);
            r.func         = FuncPoll;
            r.clock_sample = clk;
            roll           = $urandom_range(0, 99);
            if (st.got_total < reply_span()) begin
               if (roll < 45) begin
                  r.get_status = GetReady;
                  r.rx_byte    = pattern_byte(st.got_total);
               end else if (roll < 50) begin
                  r.get_status = GetReady;
               end else if (roll < 52) begin
                  r.get_status = GetFault;
               end else begin
                  r.get_status = GetEmpty;
               end
            end else begin
               r.get_status = (roll < 4) ? GetReady : (roll < 5) ? GetFault : GetEmpty;
            end
            send_item(r, 1'b0, '0);
            polls++;
         end

         // noise: any command with any content
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(random_request(), 1'b0, '0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Stall the result side in bursts of random length unless steady is set.
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Capture every result transfer at the edge; compare away from the edge so
   // the expectation pushed by the request side is always in place.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen_results.push_back(rsp_type'{rsp_tdata[7:0], rsp_tlast, rsp_tdata[8],
                                          rsp_tdata[12:9], rsp_tdata[28:13],
                                          rsp_tdata[31:29]});
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin : compare_results
      rsp_type got;
      rsp_type want;
      while (seen_results.size() != 0) begin
         got = seen_results.pop_front();
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing outstanding: %h", got);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("offered_byte", 32'(want.offered_byte), 32'(got.offered_byte));
            check_field("phase_done", 32'(want.phase_done), 32'(got.phase_done));
            check_field("passed", 32'(want.passed), 32'(got.passed));
            check_field("fail_code", 32'(want.fail_code), 32'(got.fail_code));
            check_field("sent_count", 32'(want.sent_count), 32'(got.sent_count));
            check_field("received_count", 32'(want.received_count),
                        32'(got.received_count));
         end
      end
   end

   // Abort when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles == WatchdogLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------------

   function automatic row_type item_row(req_type r);
      row_type w;
      w      = '0;
      w.item = r;
      return w;
   endfunction

   function automatic row_type typed_row(req_type r, rsp_type e);
      row_type w;
      w       = '0;
      w.item  = r;
      w.typed = 1'b1;
      w.want  = e;
      return w;
   endfunction

   function automatic row_type reg_row(logic [2:0] idx, logic [31:0] value);
      row_type w;
      w           = '0;
      w.is_reg    = 1'b1;
      w.reg_index = idx;
      w.reg_value = value;
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main
      row_type table_rows[$];
      row_type row;

      cfg.transmit_limit = TransmitLimitRst;
      cfg.receive_limit  = ReceiveLimitRst;
      cfg.quiet_units    = QuietUnitsRst;
      cfg.stall_polls    = StallPollsRst;
      cfg.blocked_waits  = BlockedWaitsRst;
      cfg.reply_pattern  = ReplyPatternRst;
      cfg.reply_count    = ReplyCountRst;
      st                 = '0;
      st.stall_left      = StallPollsRst;
      st.phase           = PhIdle;

      // Row fields: func, sample, tx_byte, tx_final, put, get, rx_byte.
      // Result fields: offered, done, passed, fail_code, sent, received.
      // poll while idle after reset: nothing moves
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h00, 8'hFF, 1'b1, PutReady, GetReady, 8'hFF},
         rsp_type'{8'h00, 1'b0, 1'b0, FailNone, 16'd0, 3'd0}));
      // transmit run, clock wraps from 0xFF to 0x00 on the first poll
      table_rows.push_back(typed_row(
         req_type'{FuncBeginTx, 8'hFF, 8'h00, 1'b0, PutReady, GetEmpty, 8'h00},
         rsp_type'{8'h00, 1'b0, 1'b0, FailNone, 16'd0, 3'd0}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h00, 8'hFF, 1'b0, PutReady, GetEmpty, 8'h00},
         rsp_type'{8'hFF, 1'b0, 1'b0, FailNone, 16'd1, 3'd0}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h01, 8'h00, 1'b0, PutBlocked, GetEmpty, 8'h00}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h03, 8'h7E, 1'b1, PutReady, GetEmpty, 8'h00}));
      // poll after the end: stored code repeats, no done pulse
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h09, 8'h33, 1'b0, PutReady, GetEmpty, 8'h00},
         rsp_type'{8'h00, 1'b0, 1'b0, FailNone, 16'd2, 3'd0}));
      // receive the default reply, then wait out the quiet interval
      table_rows.push_back(item_row(
         req_type'{FuncBeginRx, 8'h10, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h11, 8'hAA, 1'b0, PutReady, GetReady, 8'h80}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h12, 8'h00, 1'b0, PutEmpty, GetReady, 8'h01}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h13, 8'h00, 1'b0, PutEmpty, GetReady, 8'hA5}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h2B, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      // wrong first byte, then a poll on the ended exchange
      table_rows.push_back(item_row(
         req_type'{FuncBeginRx, 8'h00, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h01, 8'h00, 1'b0, PutEmpty, GetReady, 8'h00},
         rsp_type'{8'h00, 1'b1, 1'b0, FailWrong, 16'd2, 3'd0}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h02, 8'h00, 1'b0, PutEmpty, GetReady, 8'h80},
         rsp_type'{8'h00, 1'b0, 1'b0, FailWrong, 16'd2, 3'd0}));
      // transmit deadline passed on the first poll
      table_rows.push_back(item_row(
         req_type'{FuncBeginTx, 8'h00, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h80, 8'h5A, 1'b0, PutReady, GetEmpty, 8'h00},
         rsp_type'{8'h5A, 1'b1, 1'b0, FailTxTimeout, 16'd0, 3'd0}));
      // zero stall polls act as one, blocked fails, zero reply count acts as one
      table_rows.push_back(reg_row(RegStallPolls, 32'd0));
      table_rows.push_back(reg_row(RegBlockedWaits, 32'd0));
      table_rows.push_back(reg_row(RegReplyCount, 32'd0));
      table_rows.push_back(reg_row(RegReplyPattern, 32'hFFFF_FFFF));
      table_rows.push_back(reg_row(RegQuietUnits, 32'd0));
      table_rows.push_back(item_row(
         req_type'{FuncBeginTx, 8'h40, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h40, 8'h01, 1'b0, PutReady, GetEmpty, 8'h00},
         rsp_type'{8'h01, 1'b1, 1'b0, FailStall, 16'd0, 3'd0}));
      table_rows.push_back(item_row(
         req_type'{FuncBeginTx, 8'h00, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h01, 8'h80, 1'b0, PutBlocked, GetEmpty, 8'h00},
         rsp_type'{8'h80, 1'b1, 1'b0, FailTxError, 16'd0, 3'd0}));
      table_rows.push_back(item_row(
         req_type'{FuncBeginRx, 8'h00, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h01, 8'h00, 1'b0, PutEmpty, GetReady, 8'hFF}));
      // receive error, then a byte after the complete reply
      table_rows.push_back(reg_row(RegReplyCount, 32'd1));
      table_rows.push_back(reg_row(RegQuietUnits, 32'hFFFF));
      table_rows.push_back(reg_row(RegStallPolls, 32'hFFFF));
      table_rows.push_back(item_row(
         req_type'{FuncBeginRx, 8'h00, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h01, 8'h00, 1'b0, PutEmpty, GetFault, 8'h00},
         rsp_type'{8'h00, 1'b1, 1'b0, FailRxError, 16'd0, 3'd0}));
      table_rows.push_back(item_row(
         req_type'{FuncBeginRx, 8'h00, 8'h00, 1'b0, PutEmpty, GetEmpty, 8'h00}));
      table_rows.push_back(item_row(
         req_type'{FuncPoll, 8'h01, 8'h00, 1'b0, PutEmpty, GetReady, 8'hFF}));
      table_rows.push_back(typed_row(
         req_type'{FuncPoll, 8'h02, 8'h00, 1'b0, PutEmpty, GetReady, 8'hFF},
         rsp_type'{8'h00, 1'b1, 1'b0, FailExtra, 16'd0, 3'd1}));

      // hold reset, then release it at an edge
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table; register rows wait for the block to go idle
      foreach (table_rows[i]) begin
         row = table_rows[i];
         if (row.is_reg) begin
            drain();
            write_register(row.reg_index, row.reg_value);
         end else begin
            send_item(row.item, row.typed, row.want);
         end
      end

      // random exchanges: first setting at the top extremes, second at the
      // bottom, the rest mixed; drop all idling for the last setting
      items_run = 0;
      for (int ph = 0; ph < SettingCount; ph++) begin
         drain();
         apply_setting((ph == 0) ? 1 : (ph == 1) ? 2 : 0);
         if (ph == SettingCount - 1) steady <= 1'b1;
         while (items_run < (ph + 1) * ItemsPerSetting) run_exchange();
      end

      // let every outstanding result arrive, then watch for strays
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/trrc_pkg.sv
sv/trrc_step.sv
sv/timed_request_reply_checker_unit.sv
verif/tb.sv
